@@ sv/wrls_pkg.sv @@
// windowed register file with load/store: shared types, codes and defaults
// no dependencies; imported by the top level
`default_nettype none

package wrls_pkg;

  // default configuration
  localparam int NUM_WINDOWS_DEF   = 16;
  localparam int MEM_ADDR_BITS_DEF = 14;

  // command codes
  localparam logic [2:0] CMD_REG_RD = 3'd0;
  localparam logic [2:0] CMD_REG_WR = 3'd1;
  localparam logic [2:0] CMD_LOAD   = 3'd2;
  localparam logic [2:0] CMD_STORE  = 3'd3;
  localparam logic [2:0] CMD_FETCH  = 3'd4;
  localparam logic [2:0] CMD_INIT   = 3'd5;

  // access sizes
  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd2;
  localparam logic [1:0] SZ_DBL  = 2'd3;

  // status codes
  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_MISALIGN = 2'd1;
  localparam logic [1:0] STS_RANGE    = 2'd2;
  localparam logic [1:0] STS_ODD_DBL  = 2'd3;

  // register groups, bits 4:3 of the register number
  localparam logic [1:0] GRP_GLB = 2'd0;
  localparam logic [1:0] GRP_OUT = 2'd1;
  localparam logic [1:0] GRP_LOC = 2'd2;
  localparam logic [1:0] GRP_IN  = 2'd3;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [4:0]  reg_req;
    logic [3:0]  cwp;
    logic [31:0] wdata;
    logic [31:0] addr;
    logic [1:0]  size;
    logic        sign_ext;
  } in_t;

  typedef struct packed {
    logic [31:0] rdata;
    logic [1:0]  status;
  } out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DBL
  } st_t;

endpackage

`default_nettype wire

@@ sv/wrls_ram.sv @@
// generic simple dual-port ram: one write port, one registered read port
// no dependencies
`default_nettype none

module wrls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ sv/windowed_regfile_load_store.sv @@
// windowed register file with word memory: top level
// depends on wrls_pkg and wrls_ram
//
// usage:
// - input channel in_valid/in_ready/in_item carries one command item: register
//   read or write, load, store, instruction fetch or memory init write
// - result channel out_valid/out_ready/out_item returns exactly one item per
//   command: rdata and a status code
// - the block takes one item at a time; in_ready is high whenever no item is
//   in progress, even while the previous result still sits in the output
//   register
// - single accesses: the accepting edge reads the ram ports; the execute step
//   then modifies, writes back and loads the output register once it is free,
//   and a new item is taken only after the execute step is done
// - doubleword loads and stores add a second-word step after execute, as a
//   single read port is used a second time for the odd word
// - a stalled receiver holds the block in its last step; the even half of a
//   double is committed first, the rest waits for the output register
// - reset clears the globals and the window valid bits, so all registers
//   read zero; data memory words are undefined until written
`default_nettype none

module windowed_regfile_load_store #(
  parameter int NUM_WINDOWS   = wrls_pkg::NUM_WINDOWS_DEF,
  parameter int MEM_ADDR_BITS = wrls_pkg::MEM_ADDR_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output      logic          in_ready,
  input  wire wrls_pkg::in_t in_item,
  output      logic          out_valid,
  input  wire logic          out_ready,
  output      wrls_pkg::out_t out_item
);

  import wrls_pkg::*;

  localparam int WB       = $clog2(NUM_WINDOWS);
  localparam int REG_AW   = WB + 3;
  localparam int REG_DEPTH = NUM_WINDOWS * 8;
  localparam int MIW      = MEM_ADDR_BITS - 2;
  localparam int MEM_DEPTH = 1 << MIW;

  // fsm and item registers
  st_t              state_r, state_nxt;
  in_t              item_r;
  logic [WB-1:0]    win_r, winn_r;
  logic [31:0]      first_r, first_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_item_r, out_item_nxt;

  // window of the incoming item: cwp mod window count
  logic [5:0]       wtmp;
  logic [WB-1:0]    win_in, winn_in;

  always_comb begin
    wtmp = {2'b00, in_item.cwp};
    for (int i = 0; i < 8; i++) begin
      if (wtmp >= 6'(NUM_WINDOWS)) begin
        wtmp = wtmp - 6'(NUM_WINDOWS);
      end
    end
    win_in  = wtmp[WB-1:0];
    winn_in = (win_in == WB'(NUM_WINDOWS - 1)) ? '0 : win_in + WB'(1);
  end

  // register file storage: globals in flops, outs and locals in rams
  logic [31:0]      glb_r [8];
  logic             out_vld_r [REG_DEPTH];
  logic             loc_vld_r [REG_DEPTH];
  logic [31:0]      glb_q_r;
  logic             out_vq_r, loc_vq_r;
  logic [1:0]       rsel_r;
  logic [31:0]      out_q, loc_q, mem_q;

  // read request
  logic             rr_en;
  logic [4:0]       rr_reg;
  logic [WB-1:0]    rr_win, rr_winn;
  logic [REG_AW-1:0] ro_addr, rl_addr;

  // write request
  logic             rw_en;
  logic [4:0]       rw_reg;
  logic [31:0]      rw_data;
  logic             glb_we, out_we, loc_we;
  logic [REG_AW-1:0] wo_addr, wl_addr;

  // data memory
  logic             mrd_en, mwr_en;
  logic [MIW-1:0]   mrd_idx, mwr_idx, idx_r, idx2_r;
  logic [31:0]      mwr_data;

  logic [31:0]      regval, lane_v, merged;
  logic             out_free, dbl_go;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign out_free  = !out_valid_r || out_ready;

  assign idx_r  = item_r.addr[MEM_ADDR_BITS-1:2];
  assign idx2_r = idx_r + MIW'(1);

  // read address decode; the idle step reads for the incoming item
  assign rr_win  = (state_r == S_IDLE) ? win_in  : win_r;
  assign rr_winn = (state_r == S_IDLE) ? winn_in : winn_r;
  assign ro_addr = {(rr_reg[4:3] == GRP_IN) ? rr_winn : rr_win, rr_reg[2:0]};
  assign rl_addr = {rr_win, rr_reg[2:0]};

  // write address decode; g0 writes are dropped
  assign glb_we  = rw_en && (rw_reg[4:3] == GRP_GLB) && (rw_reg[2:0] != 3'd0);
  assign out_we  = rw_en && ((rw_reg[4:3] == GRP_OUT) || (rw_reg[4:3] == GRP_IN));
  assign loc_we  = rw_en && (rw_reg[4:3] == GRP_LOC);
  assign wo_addr = {(rw_reg[4:3] == GRP_IN) ? winn_r : win_r, rw_reg[2:0]};
  assign wl_addr = {win_r, rw_reg[2:0]};

  // register value from the last read; unwritten window entries read zero
  always_comb begin
    case (rsel_r)
      GRP_GLB: regval = glb_q_r;
      GRP_LOC: regval = loc_vq_r ? loc_q : 32'd0;
      default: regval = out_vq_r ? out_q : 32'd0;
    endcase
  end

  // load lane select with optional sign extension
  always_comb begin
    case (item_r.size)
      SZ_BYTE: begin
        lane_v = {24'd0, mem_q[{item_r.addr[1:0], 3'b000} +: 8]};
        if (item_r.sign_ext && lane_v[7]) begin
          lane_v = lane_v | 32'hffffff00;
        end
      end
      SZ_HALF: begin
        lane_v = {16'd0, mem_q[{item_r.addr[1], 4'b0000} +: 16]};
        if (item_r.sign_ext && lane_v[15]) begin
          lane_v = lane_v | 32'hffff0000;
        end
      end
      default: lane_v = mem_q;
    endcase
  end

  // store lane merge into the addressed word
  always_comb begin
    merged = mem_q;
    case (item_r.size)
      SZ_BYTE: merged[{item_r.addr[1:0], 3'b000} +: 8] = regval[7:0];
      SZ_HALF: merged[{item_r.addr[1], 4'b0000} +: 16] = regval[15:0];
      default: merged = regval;
    endcase
  end

  assign dbl_go = ((item_r.cmd == CMD_LOAD) || (item_r.cmd == CMD_STORE)) &&
                  (item_r.size == SZ_DBL) && !item_r.reg_req[0];

  // next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_item_nxt  = out_item_r;
    first_nxt     = first_r;
    rr_en         = 1'b0;
    rr_reg        = in_item.reg_req;
    mrd_en        = 1'b0;
    mrd_idx       = in_item.addr[MEM_ADDR_BITS-1:2];
    mwr_en        = 1'b0;
    mwr_idx       = idx_r;
    mwr_data      = merged;
    rw_en         = 1'b0;
    rw_reg        = item_r.reg_req;
    rw_data       = lane_v;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          rr_en     = 1'b1;
          mrd_en    = 1'b1;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        if (dbl_go) begin
          // even word now, odd word in the next step
          if (item_r.cmd == CMD_LOAD) begin
            rw_en     = 1'b1;
            rw_data   = mem_q;
            first_nxt = mem_q;
            mrd_en    = 1'b1;
            mrd_idx   = idx2_r;
          end else begin
            mwr_en   = 1'b1;
            mwr_data = regval;
            rr_en    = 1'b1;
            rr_reg   = {item_r.reg_req[4:1], 1'b1};
          end
          state_nxt = S_DBL;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{rdata: 32'd0, status: STS_OK};
          case (item_r.cmd)
            CMD_REG_RD: out_item_nxt.rdata = regval;
            CMD_REG_WR: begin
              rw_en   = 1'b1;
              rw_data = item_r.wdata;
            end
            CMD_LOAD: begin
              if (item_r.size == SZ_DBL) begin
                out_item_nxt.status = STS_ODD_DBL;
              end else begin
                rw_en              = 1'b1;
                out_item_nxt.rdata = lane_v;
              end
            end
            CMD_STORE: begin
              if (item_r.size == SZ_DBL) begin
                out_item_nxt.status = STS_ODD_DBL;
              end else begin
                mwr_en = 1'b1;
              end
            end
            CMD_FETCH: begin
              if (item_r.addr[1:0] != 2'b00) begin
                out_item_nxt.status = STS_MISALIGN;
              end else begin
                out_item_nxt.rdata = mem_q;
              end
            end
            CMD_INIT: begin
              if (|item_r.addr[31:MEM_ADDR_BITS]) begin
                out_item_nxt.status = STS_RANGE;
              end else begin
                mwr_en   = 1'b1;
                mwr_data = item_r.wdata;
              end
            end
            default: ;
          endcase
          state_nxt = S_IDLE;
        end
      end

      S_DBL: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{rdata: 32'd0, status: STS_OK};
          if (item_r.cmd == CMD_LOAD) begin
            rw_en              = 1'b1;
            rw_reg             = {item_r.reg_req[4:1], 1'b1};
            rw_data            = mem_q;
            out_item_nxt.rdata = first_r;
          end else begin
            mwr_en   = 1'b1;
            mwr_idx  = idx2_r;
            mwr_data = regval;
          end
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // item capture and payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
      win_r  <= win_in;
      winn_r <= winn_in;
    end
    first_r    <= first_nxt;
    out_item_r <= out_item_nxt;
    if (rr_en) begin
      glb_q_r  <= glb_r[rr_reg[2:0]];
      out_vq_r <= out_vld_r[ro_addr];
      loc_vq_r <= loc_vld_r[rl_addr];
      rsel_r   <= rr_reg[4:3];
    end
  end

  // globals and window valid bits, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        glb_r[i] <= 32'd0;
      end
      for (int i = 0; i < REG_DEPTH; i++) begin
        out_vld_r[i] <= 1'b0;
        loc_vld_r[i] <= 1'b0;
      end
    end else begin
      if (glb_we) begin
        glb_r[rw_reg[2:0]] <= rw_data;
      end
      if (out_we) begin
        out_vld_r[wo_addr] <= 1'b1;
      end
      if (loc_we) begin
        loc_vld_r[wl_addr] <= 1'b1;
      end
    end
  end

  // outs of all windows (ins alias the next window's outs)
  wrls_ram #(.WIDTH(32), .DEPTH(REG_DEPTH)) u_out_ram (
    .clk   (clk),
    .we    (out_we),
    .waddr (wo_addr),
    .wdata (rw_data),
    .re    (rr_en),
    .raddr (ro_addr),
    .rdata (out_q)
  );

  // locals of all windows
  wrls_ram #(.WIDTH(32), .DEPTH(REG_DEPTH)) u_loc_ram (
    .clk   (clk),
    .we    (loc_we),
    .waddr (wl_addr),
    .wdata (rw_data),
    .re    (rr_en),
    .raddr (rl_addr),
    .rdata (loc_q)
  );

  // word-organized data memory
  wrls_ram #(.WIDTH(32), .DEPTH(MEM_DEPTH)) u_mem_ram (
    .clk   (clk),
    .we    (mwr_en),
    .waddr (mwr_idx),
    .wdata (mwr_data),
    .re    (mrd_en),
    .raddr (mrd_idx),
    .rdata (mem_q)
  );

`ifndef SYNTH
  // results only come out of an execute or second-word step
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_EXEC || $past(state_r) == S_DBL))
    else $error("result produced outside an execute step");

  // no state is modified while idle
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !(mwr_en || rw_en))
    else $error("write while idle");

  // second-word step only follows an execute step or itself
  a_dbl_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DBL) |-> ($past(state_r) == S_EXEC || $past(state_r) == S_DBL))
    else $error("second-word step out of order");

  // an accepted item always moves into execute
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_EXEC))
    else $error("accepted item not executed");
`endif

endmodule

`default_nettype wire

@@ test/windowed_regfile_load_store_tb.sv @@
`timescale 1ns / 100ps
// testbench for windowed_regfile_load_store: directed and random command items,
// each result checked against an in-bench register window and memory predictor
// depends on wrls_pkg and the windowed_regfile_load_store rtl

module windowed_regfile_load_store_tb;
  import wrls_pkg::*;

  localparam int NWIN        = NUM_WINDOWS_DEF;
  localparam int MAB         = MEM_ADDR_BITS_DEF;
  localparam int MEM_WORDS   = 1 << (MAB - 2);
  localparam longint unsigned MEM_BYTES = 64'd1 << MAB;
  localparam int N_RANDOM    = 900;
  localparam int HOLD_CYCLES = 300;

  // command codes the block must ignore
  localparam logic [2:0] CMD_RSVD6 = 3'd6;
  localparam logic [2:0] CMD_RSVD7 = 3'd7;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_item   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_item;

  windowed_regfile_load_store i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  // predictor state: globals, per-window outs and locals, memory image
  logic [31:0] glb_regs [8]         = '{default: '0};
  logic [31:0] win_outs [NWIN * 8]  = '{default: '0};
  logic [31:0] win_locs [NWIN * 8]  = '{default: '0};
  logic [31:0] mem_img  [MEM_WORDS];

  // stimulus side: words whose four bytes have all been written
  bit mem_ok [MEM_WORDS];

  in_t  cmd_q[$];      // items waiting for the driver
  out_t rsp_due_q[$];  // predicted results, oldest first

  int n_by_cmd [8];
  int n_checked = 0;
  int n_bad     = 0;
  int n_holds   = 0;
  int hold_left = 0;
  int tx_gap    = 0;
  int rx_gap    = 0;
  int tx_calm   = 0;
  int rx_calm   = 0;
  int rx_pick;

  initial begin
    forever #1 clk = ~clk;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #1_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // register window mapping: 0-7 globals, 8-15 outs, 16-23 locals,
  // 24-31 ins which alias the outs of the next window
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] win_reg_rd(logic [4:0] r, logic [3:0] cwp);
    int w;
    w = cwp % NWIN;
    case (r[4:3])
      GRP_GLB: return glb_regs[r[2:0]];
      GRP_OUT: return win_outs[w * 8 + r[2:0]];
      GRP_LOC: return win_locs[w * 8 + r[2:0]];
      default: return win_outs[((w + 1) % NWIN) * 8 + r[2:0]];
    endcase
  endfunction

  function automatic void win_reg_wr(logic [4:0] r, logic [3:0] cwp, logic [31:0] v);
    int w;
    w = cwp % NWIN;
    case (r[4:3])
      GRP_GLB: if (r[2:0] != 3'd0) glb_regs[r[2:0]] = v;  // g0 stays zero
      GRP_OUT: win_outs[w * 8 + r[2:0]] = v;
      GRP_LOC: win_locs[w * 8 + r[2:0]] = v;
      default: win_outs[((w + 1) % NWIN) * 8 + r[2:0]] = v;
    endcase
  endfunction

  // executes one command on the predictor state, returns its result
  function automatic out_t apply_cmd(in_t it);
    out_t res;
    int unsigned wi, wi2;
    logic [31:0] word, v;
    res  = '0;
    wi   = (it.addr >> 2) % MEM_WORDS;   // address wraps at memory size
    wi2  = (wi + 1) % MEM_WORDS;         // second word of a double
    word = mem_img[wi];
    case (it.cmd)
      CMD_REG_RD: res.rdata = win_reg_rd(it.reg_req, it.cwp);
      CMD_REG_WR: win_reg_wr(it.reg_req, it.cwp, it.wdata);
      CMD_LOAD: begin
        if (it.size == SZ_DBL && it.reg_req[0]) begin
          res.status = STS_ODD_DBL;
        end else begin
          case (it.size)
            SZ_BYTE: begin
              v = {24'h0, word[it.addr[1:0] * 8 +: 8]};
              if (it.sign_ext && v[7]) v[31:8] = '1;
            end
            SZ_HALF: begin
              v = {16'h0, word[it.addr[1] * 16 +: 16]};
              if (it.sign_ext && v[15]) v[31:16] = '1;
            end
            default: v = word;
          endcase
          win_reg_wr(it.reg_req, it.cwp, v);
          if (it.size == SZ_DBL) win_reg_wr(it.reg_req | 5'd1, it.cwp, mem_img[wi2]);
          res.rdata = v;
        end
      end
      CMD_STORE: begin
        v = win_reg_rd(it.reg_req, it.cwp);
        case (it.size)
          SZ_BYTE: word[it.addr[1:0] * 8 +: 8] = v[7:0];
          SZ_HALF: word[it.addr[1] * 16 +: 16] = v[15:0];
          default: word = v;
        endcase
        if (it.size != SZ_DBL) begin
          mem_img[wi] = word;
        end else if (it.reg_req[0]) begin
          res.status = STS_ODD_DBL;
        end else begin
          mem_img[wi]  = v;
          mem_img[wi2] = win_reg_rd(it.reg_req | 5'd1, it.cwp);
        end
      end
      CMD_FETCH: begin
        if (it.addr[1:0] != 2'b00) res.status = STS_MISALIGN;
        else res.rdata = word;
      end
      CMD_INIT: begin
        if (it.addr >= MEM_BYTES) res.status = STS_RANGE;
        else mem_img[wi] = it.wdata;
      end
      default: ;  // unused codes change nothing
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic in_t cmd_item(logic [2:0] cmd, logic [4:0] r, logic [3:0] cwp,
                                   logic [31:0] wd, logic [31:0] a, logic [1:0] sz,
                                   logic sx);
    in_t it;
    it.cmd      = cmd;
    it.reg_req  = r;
    it.cwp      = cwp;
    it.wdata    = wd;
    it.addr     = a;
    it.size     = sz;
    it.sign_ext = sx;
    return it;
  endfunction

  // items run in order, so readability can be tracked at generation time
  task automatic queue_cmd(in_t it);
    if (it.cmd == CMD_INIT && it.addr < MEM_BYTES) mem_ok[(it.addr >> 2) % MEM_WORDS] = 1'b1;
    cmd_q.push_back(it);
  endtask

  // word pool at both ends of memory so wrap and all index bits get exercised
  function automatic int unsigned pool_word();
    int unsigned k;
    k = $urandom_range(0, 63);
    return (k < 32) ? k : MEM_WORDS - 64 + k;
  endfunction

  // address of a written word (and its successor for doubles), with junk above the
  // memory range, which must be ignored, and random byte offset bits
  function automatic logic [31:0] pick_mem_addr(bit pair);
    int unsigned wi, c;
    bit found;
    logic [31:0] hi;
    wi    = MEM_WORDS - 1;  // last word and word 0 are written first thing
    found = 1'b0;
    for (int k = 0; k < 64 && !found; k++) begin
      c = pool_word();
      if (mem_ok[c] && (!pair || mem_ok[(c + 1) % MEM_WORDS])) begin
        wi    = c;
        found = 1'b1;
      end
    end
    hi = $urandom_range(0, 1) ? $urandom : 32'h0;
    return (hi << MAB) | (32'(wi) << 2) | 32'($urandom_range(0, 3));
  endfunction

  function automatic logic [31:0] rand_word();
    int k;
    k = $urandom_range(0, 99);
    if (k < 8) return '1;
    if (k < 16) return '0;
    return $urandom;
  endfunction

  // idle length: mostly none, some short, a few long, with calm stretches
  function automatic int pick_gap(inout int calm);
    int k;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    k = $urandom_range(0, 99);
    if (k < 3) calm = $urandom_range(20, 60);
    if (k < 55) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // ---------------------------------------------------------------------------
  // driver: presents items from cmd_q, predicts each one as it is accepted
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap   <= 0;
    end else begin
      if (in_valid && in_ready) begin
        rsp_due_q.push_back(apply_cmd(in_item));
        n_by_cmd[in_item.cmd]++;
      end
      // payload may only move when nothing is offered or it was just taken
      if (!in_valid || in_ready) begin
        if (tx_gap != 0) begin
          tx_gap   <= tx_gap - 1;
          in_valid <= 1'b0;
        end else if (cmd_q.size() != 0) begin
          in_item  <= cmd_q.pop_front();
          in_valid <= 1'b1;
          tx_gap   <= pick_gap(tx_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: compares each accepted result with the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic check_rsp(out_t got);
    out_t want;
    if (rsp_due_q.size() == 0) begin
      n_bad++;
      if (n_bad <= 10)
        $display("%0t: result with no item pending: rdata %h status %0d",
                 $realtime, got.rdata, got.status);
    end else begin
      want = rsp_due_q.pop_front();
      if (got.rdata !== want.rdata || got.status !== want.status) begin
        n_bad++;
        if (n_bad <= 10)
          $display("%0t: mismatch on result %0d: rdata exp %h got %h, status exp %0d got %0d",
                   $realtime, n_checked, want.rdata, got.rdata, want.status, got.status);
      end
    end
    n_checked <= n_checked + 1;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_gap    <= 0;
    end else if (out_valid && out_ready) begin
      check_rsp(out_item);
      rx_pick = pick_gap(rx_calm);
      rx_gap    <= rx_pick;
      out_ready <= (rx_pick == 0) && (hold_left == 0);
    end else if (rx_gap != 0) begin
      rx_gap    <= rx_gap - 1;
      out_ready <= 1'b0;
    end else begin
      // occasional single-cycle drops while waiting for a result
      out_ready <= (hold_left == 0) && (rx_calm > 0 || $urandom_range(0, 7) != 0);
    end
  end

  // long receiver hold-offs while the driver keeps offering, so the block
  // backs up and drops in_ready
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      n_holds   <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (n_holds < 2 && n_checked >= 250 + 400 * n_holds) begin
      hold_left <= HOLD_CYCLES;
      n_holds   <= n_holds + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int sel, w, cur_win;
    logic [2:0]  cmd;
    logic [4:0]  r;
    logic [1:0]  sz;
    logic [31:0] a;

    // directed: seed last and first word, so wrapped doubles are legal
    queue_cmd(cmd_item(CMD_INIT, 5'd0, 4'd0, 32'h01ff_7f80, 32'h0000_3ffc, SZ_WORD, 1'b0));
    queue_cmd(cmd_item(CMD_INIT, 5'd0, 4'd0, 32'h8000_7fff, 32'h0000_0001, SZ_BYTE, 1'b1));
    // init beyond memory range, no write
    queue_cmd(cmd_item(CMD_INIT, 5'd0, 4'd0, 32'hffff_ffff, 32'h0000_4000, SZ_WORD, 1'b0));
    queue_cmd(cmd_item(CMD_INIT, 5'd31, 4'd15, 32'h0, 32'hffff_ffff, SZ_DBL, 1'b1));
    // g0 ignores writes
    queue_cmd(cmd_item(CMD_REG_WR, 5'd0, 4'd0, 32'hffff_ffff, 32'h0, SZ_WORD, 1'b0));
    queue_cmd(cmd_item(CMD_REG_RD, 5'd0, 4'd0, 32'h0, 32'h0, SZ_WORD, 1'b0));
    // ins of the top window are the outs of window 0
    queue_cmd(cmd_item(CMD_REG_WR, 5'd31, 4'd15, 32'hdead_beef, 32'h0, SZ_WORD, 1'b0));
    queue_cmd(cmd_item(CMD_REG_RD, 5'd15, 4'd0, 32'h0, 32'h0, SZ_WORD, 1'b0));
    queue_cmd(cmd_item(CMD_REG_WR, 5'd16, 4'd5, 32'h1234_5678, 32'h0, SZ_WORD, 1'b0));
    queue_cmd(cmd_item(CMD_REG_RD, 5'd16, 4'd5, 32'h0, 32'h0, SZ_WORD, 1'b0));
    // lane loads, signed and unsigned, with high address bits to be dropped
    queue_cmd(cmd_item(CMD_LOAD, 5'd1, 4'd0, 32'h0, 32'hffff_fffc, SZ_BYTE, 1'b1));
    queue_cmd(cmd_item(CMD_LOAD, 5'd2, 4'd0, 32'h0, 32'h0000_3fff, SZ_BYTE, 1'b0));
    queue_cmd(cmd_item(CMD_LOAD, 5'd3, 4'd0, 32'h0, 32'h0000_0003, SZ_HALF, 1'b1));
    queue_cmd(cmd_item(CMD_LOAD, 5'd24, 4'd15, 32'h0, 32'h0000_0000, SZ_HALF, 1'b0));
    queue_cmd(cmd_item(CMD_LOAD, 5'd8, 4'd3, 32'h0, 32'h0000_3ffe, SZ_WORD, 1'b1));
    // double that wraps from the last word to word 0, and an odd double
    queue_cmd(cmd_item(CMD_LOAD, 5'd30, 4'd7, 32'h0, 32'h0000_3ffc, SZ_DBL, 1'b0));
    queue_cmd(cmd_item(CMD_LOAD, 5'd5, 4'd7, 32'h0, 32'h0000_3ffc, SZ_DBL, 1'b0));
    // stores of every size
    queue_cmd(cmd_item(CMD_STORE, 5'd1, 4'd0, 32'h0, 32'h0000_0002, SZ_BYTE, 1'b0));
    queue_cmd(cmd_item(CMD_STORE, 5'd31, 4'd15, 32'h0, 32'h8000_3ffe, SZ_HALF, 1'b0));
    queue_cmd(cmd_item(CMD_STORE, 5'd16, 4'd5, 32'h0, 32'h0000_0000, SZ_WORD, 1'b0));
    queue_cmd(cmd_item(CMD_STORE, 5'd30, 4'd7, 32'h0, 32'h0000_3ffc, SZ_DBL, 1'b0));
    queue_cmd(cmd_item(CMD_STORE, 5'd7, 4'd7, 32'h0, 32'h0000_3ffc, SZ_DBL, 1'b0));
    // aligned and misaligned fetch
    queue_cmd(cmd_item(CMD_FETCH, 5'd0, 4'd0, 32'h0, 32'h0000_3ffc, SZ_WORD, 1'b0));
    queue_cmd(cmd_item(CMD_FETCH, 5'd0, 4'd0, 32'h0, 32'h0000_3ffd, SZ_WORD, 1'b0));
    // unused codes
    queue_cmd(cmd_item(CMD_RSVD6, 5'd9, 4'd2, 32'hffff_ffff, 32'h0, SZ_WORD, 1'b1));
    queue_cmd(cmd_item(CMD_RSVD7, 5'd9, 4'd2, 32'hffff_ffff, 32'h0, SZ_DBL, 1'b1));

    // random: windows mostly near a drifting current window so that writes,
    // loads and reads meet, including across the in/out overlap
    cur_win = 0;
    for (int n = 0; n < N_RANDOM; n++) begin
      if ($urandom_range(0, 19) == 0) cur_win = $urandom_range(0, NWIN - 1);
      sel = $urandom_range(0, 99);
      if (sel < 14) cmd = CMD_REG_WR;
      else if (sel < 26) cmd = CMD_REG_RD;
      else if (sel < 48) cmd = CMD_LOAD;
      else if (sel < 66) cmd = CMD_STORE;
      else if (sel < 76) cmd = CMD_FETCH;
      else if (sel < 92) cmd = CMD_INIT;
      else cmd = $urandom_range(0, 1) ? CMD_RSVD6 : CMD_RSVD7;
      sz = 2'($urandom_range(0, 3));
      r  = 5'($urandom_range(0, 31));
      if (sz == SZ_DBL && $urandom_range(0, 4) != 0) r[0] = 1'b0;
      if ($urandom_range(0, 3) != 0) w = (cur_win + $urandom_range(0, 1)) % NWIN;
      else w = $urandom_range(0, NWIN - 1);
      if (cmd == CMD_INIT) begin
        if ($urandom_range(0, 6) == 0) a = $urandom | (32'h1 << $urandom_range(MAB, 31));
        else a = (pool_word() << 2) | 32'($urandom_range(0, 3));
      end else begin
        a = pick_mem_addr(sz == SZ_DBL);
        if (cmd == CMD_FETCH && $urandom_range(0, 9) < 7) a[1:0] = 2'b00;
      end
      queue_cmd(cmd_item(cmd, r, 4'(w), rand_word(), a, sz, 1'($urandom_range(0, 1))));
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (cmd_q.size() != 0 || in_valid) @(posedge clk);
    while (rsp_due_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);  // catch stray results

    $display("items run: %0d reg reads, %0d reg writes, %0d loads, %0d stores, %0d fetches",
             n_by_cmd[CMD_REG_RD], n_by_cmd[CMD_REG_WR], n_by_cmd[CMD_LOAD],
             n_by_cmd[CMD_STORE], n_by_cmd[CMD_FETCH]);
    $display("  %0d inits, %0d unused codes; %0d results checked, %0d long stalls, %0d failures",
             n_by_cmd[CMD_INIT], n_by_cmd[CMD_RSVD6] + n_by_cmd[CMD_RSVD7], n_checked,
             n_holds, n_bad);
    if (n_bad == 0 && rsp_due_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ windowed_regfile_load_store.f @@
sv/wrls_pkg.sv
sv/wrls_ram.sv
sv/windowed_regfile_load_store.sv
test/windowed_regfile_load_store_tb.sv
